// File: hw/rtl/asa_pkg.sv
// shared constants, codes and control types for the accelerated step adjuster
// no dependencies; every other file of the block imports this package
package asa_pkg;

   // payload and register widths
   localparam int TYPE_W     = 3;
   localparam int OFFSET_W   = 18;
   localparam int STEP_W     = 20;
   localparam int BASE_W     = 10;
   localparam int TICKS_W    = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam int ELAPSED_WIDTH_DEF = 16;

   // request codes
   localparam logic [TYPE_W-1:0] REQ_TICK   = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_UP     = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_DOWN   = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_ZERO   = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_CANCEL = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BASE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FAST = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOW = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE = 2'd3;

   // register reset values
   localparam logic [BASE_W-1:0]  BASE_RESET = 10'd1;
   localparam logic [TICKS_W-1:0] FAST_RESET = 16'd500;
   localparam logic [TICKS_W-1:0] SLOW_RESET = 16'd1500;
   localparam logic [TICKS_W-1:0] IDLE_RESET = 16'd2500;

   // limits
   localparam logic [BASE_W-1:0]  BASE_MIN   = 10'd1;
   localparam logic [BASE_W-1:0]  BASE_MAX   = 10'd1000;
   localparam logic [STEP_W-1:0]  STEP_MAX   = 20'd1000000;
   localparam logic [STEP_W-1:0]  STEP_MIN   = 20'd1;
   localparam logic [STEP_W-1:0]  STEP_RESET = 20'd1;
   localparam logic [STEP_W-1:0]  SLOW_MUL   = 20'd5;
   localparam logic [STEP_W-1:0]  FAST_MUL   = 20'd500;
   localparam logic signed [OFFSET_W-1:0] OFS_MIN = 18'sh20000;
   localparam logic signed [OFFSET_W-1:0] OFS_MAX = 18'sh1FFFF;

   // divide by ten through a reciprocal: exact for steps below 2**22
   localparam int RECIP_W     = 21;
   localparam int RECIP_SHIFT = 24;
   localparam logic [RECIP_W-1:0] RECIP_10 = 21'd1677722;

   // restoring divider for rounding: dividend 2|x|+m, divisor 2m
   localparam int DIV_W = 21;
   localparam int CNT_W = $clog2(DIV_W);
   localparam int QMOD_W = 4;
   localparam logic [QMOD_W:0] DECADE = 5'd10;

   typedef struct packed {
      logic load;      // capture the word and set up the divider
      logic div_step;  // one divider iteration
      logic commit;    // update state and load the result register
   } asa_cmd_type;

   typedef struct packed {
      logic is_press;  // captured word is step up or step down
      logic div_last;  // divider is on its final iteration
   } asa_status_type;

endpackage

// File: hw/rtl/asa_req_if.sv
// request channel of the accelerated step adjuster: valid/ready and payload
// depends on asa_pkg
interface asa_req_if import asa_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [TYPE_W-1:0]          req_type;
   logic signed [OFFSET_W-1:0] altitude;

   modport source (output valid, req_type, altitude, input ready);
   modport sink (input valid, req_type, altitude, output ready);
endinterface

// File: hw/rtl/asa_rsp_if.sv
// response channel of the accelerated step adjuster: valid/ready and payload
// depends on asa_pkg
interface asa_rsp_if import asa_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [OFFSET_W-1:0] offset_out;
   logic                       changed;
   logic [STEP_W-1:0]          step_out;

   modport source (output valid, offset_out, changed, step_out, input ready);
   modport sink (input valid, offset_out, changed, step_out, output ready);
endinterface

// File: hw/rtl/asa_ctrl.sv
// control state machine of the accelerated step adjuster
// depends on asa_pkg; drives asa_dpath through asa_cmd_type
module asa_ctrl import asa_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  logic           rsp_ready,
   output logic           rsp_valid,
   input  asa_status_type status,
   output asa_cmd_type    cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_DIV    = 2'd1;
   localparam logic [1:0] S_COMMIT = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (!status.is_press || status.div_last) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            // wait for the result register to be free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: hw/rtl/asa_dpath.sv
// datapath of the accelerated step adjuster: registers, offset/step state,
// rounding divider and result register; depends on asa_pkg
module asa_dpath import asa_pkg::*; #(
   parameter int ELAPSED_WIDTH = ELAPSED_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  asa_cmd_type                cmd,
   output asa_status_type             status,
   input  logic [TYPE_W-1:0]          req_type,
   input  logic signed [OFFSET_W-1:0] req_altitude,
   input  logic                       csr_we,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata,
   output logic signed [OFFSET_W-1:0] offset_out,
   output logic                       changed,
   output logic [STEP_W-1:0]          step_out
);

   localparam int CMP_W  = (ELAPSED_WIDTH > TICKS_W) ? ELAPSED_WIDTH : TICKS_W;
   localparam int SUM_W  = OFFSET_W + 4;
   localparam int X10_W  = STEP_W + 4;
   localparam int PROD_W = STEP_W + RECIP_W;

   // registers
   logic [BASE_W-1:0]  base_ff;
   logic [TICKS_W-1:0] fast_ff, slow_ff, idle_ff;

   // captured word
   logic [TYPE_W-1:0]          type_ff;
   logic signed [OFFSET_W-1:0] alt_ff;

   // block state
   logic signed [OFFSET_W-1:0] offset_ff, offset_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic [ELAPSED_WIDTH-1:0]   elapsed_ff, elapsed_in;

   // divider
   logic [DIV_W-1:0]  num_ff, rem_ff, rem_in;
   logic [CNT_W-1:0]  cnt_ff;
   logic [QMOD_W-1:0] qmod_ff, qmod_in;
   logic [PROD_W-1:0] prod_ff;

   // result register
   logic signed [OFFSET_W-1:0] offset_out_ff;
   logic                       changed_ff;
   logic [STEP_W-1:0]          step_out_ff;

   logic [OFFSET_W-1:0] abs_off;
   logic [DIV_W-1:0]    div_num, div_den;
   logic [DIV_W:0]      trial, diff;
   logic                fits;
   logic [QMOD_W:0]     qm2;
   logic [BASE_W-1:0]   base_eff;
   logic [STEP_W-1:0]   base_x, base_x5, base_x500, div10, step_new;
   logic [X10_W-1:0]    step_x10;
   logic [CMP_W-1:0]    el_x;
   logic                idle_hit, slow_hit, fast_hit, is_press;
   logic signed [SUM_W-1:0] off_x, step_s, alt_x;

   function automatic logic signed [OFFSET_W-1:0] sat_off(
      input logic signed [SUM_W-1:0] v
   );
      logic signed [OFFSET_W-1:0] r;
      if (v < SUM_W'(OFS_MIN)) begin
         r = OFS_MIN;
      end else if (v > SUM_W'(OFS_MAX)) begin
         r = OFS_MAX;
      end else begin
         r = OFFSET_W'(v);
      end
      return r;
   endfunction

   // rounding divider: quotient bit by bit, only its value mod ten is kept
   always_comb begin
      abs_off = offset_ff[OFFSET_W-1] ? OFFSET_W'(-offset_ff) : OFFSET_W'(offset_ff);
      div_num = DIV_W'({abs_off, 1'b0}) + DIV_W'(step_ff);
      div_den = {step_ff, 1'b0};
      trial   = {rem_ff, num_ff[DIV_W-1]};
      diff    = trial - {1'b0, div_den};
      fits    = (trial >= {1'b0, div_den});
      rem_in  = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      qm2     = {qmod_ff, fits};
      qmod_in = (qm2 >= DECADE) ? QMOD_W'(qm2 - DECADE) : qm2[QMOD_W-1:0];
   end

   // step adaptation
   always_comb begin
      if (base_ff == '0) begin
         base_eff = BASE_MIN;
      end else if (base_ff > BASE_MAX) begin
         base_eff = BASE_MAX;
      end else begin
         base_eff = base_ff;
      end
      base_x    = STEP_W'(base_eff);
      base_x5   = base_x * SLOW_MUL;
      base_x500 = base_x * FAST_MUL;
      div10     = STEP_W'(prod_ff[PROD_W-1:RECIP_SHIFT]);
      step_x10  = X10_W'({step_ff, 3'b000}) + X10_W'({step_ff, 1'b0});
      el_x      = CMP_W'(elapsed_ff);

      idle_hit = el_x > CMP_W'(idle_ff);
      slow_hit = (el_x > CMP_W'(slow_ff)) && (step_ff > base_x5);
      // rounded to m equals rounded to 10m exactly when the rounded quotient is a decade
      fast_hit = (el_x < CMP_W'(fast_ff)) && (step_ff < base_x500) && (qmod_ff == '0);

      if (idle_hit) begin
         step_new = base_x;
      end else if (slow_hit) begin
         step_new = (div10 == '0) ? STEP_MIN : div10;
      end else if (fast_hit) begin
         step_new = (step_x10 > X10_W'(STEP_MAX)) ? STEP_MAX : STEP_W'(step_x10);
      end else begin
         step_new = step_ff;
      end
   end

   // next state
   always_comb begin
      is_press   = (type_ff == REQ_UP) || (type_ff == REQ_DOWN);
      step_in    = is_press ? step_new : step_ff;
      off_x      = SUM_W'(offset_ff);
      alt_x      = SUM_W'(alt_ff);
      step_s     = $signed(SUM_W'(step_in));
      offset_in  = offset_ff;
      elapsed_in = elapsed_ff;
      case (type_ff)
         REQ_TICK: begin
            if (elapsed_ff != '1) begin
               elapsed_in = elapsed_ff + 1'b1;
            end
         end
         REQ_UP: begin
            offset_in  = sat_off(off_x + step_s);
            elapsed_in = '0;
         end
         REQ_DOWN: begin
            offset_in  = sat_off(off_x - step_s);
            elapsed_in = '0;
         end
         REQ_ZERO: begin
            offset_in = '0;
         end
         REQ_CANCEL: begin
            offset_in = sat_off(off_x - alt_x);
         end
         default: begin
            offset_in = offset_ff;
         end
      endcase
   end

   assign status.is_press = is_press;
   assign status.div_last = (cnt_ff == CNT_W'(DIV_W - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff    <= BASE_RESET;
         fast_ff    <= FAST_RESET;
         slow_ff    <= SLOW_RESET;
         idle_ff    <= IDLE_RESET;
         offset_ff  <= '0;
         step_ff    <= STEP_RESET;
         elapsed_ff <= '1;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_BASE: base_ff <= csr_wdata[BASE_W-1:0];
               CSR_FAST: fast_ff <= csr_wdata[TICKS_W-1:0];
               CSR_SLOW: slow_ff <= csr_wdata[TICKS_W-1:0];
               CSR_IDLE: idle_ff <= csr_wdata[TICKS_W-1:0];
               default: begin
               end
            endcase
         end
         if (cmd.commit) begin
            offset_ff  <= offset_in;
            step_ff    <= step_in;
            elapsed_ff <= elapsed_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(step_ff) * PROD_W'(RECIP_10);
      if (cmd.load) begin
         type_ff <= req_type;
         alt_ff  <= req_altitude;
         num_ff  <= div_num;
         rem_ff  <= '0;
         qmod_ff <= '0;
         cnt_ff  <= '0;
      end else if (cmd.div_step) begin
         num_ff  <= {num_ff[DIV_W-2:0], 1'b0};
         rem_ff  <= rem_in;
         qmod_ff <= qmod_in;
         cnt_ff  <= cnt_ff + 1'b1;
      end
      if (cmd.commit) begin
         offset_out_ff <= offset_in;
         changed_ff    <= (offset_in != offset_ff);
         step_out_ff   <= step_in;
      end
   end

   assign offset_out = offset_out_ff;
   assign changed    = changed_ff;
   assign step_out   = step_out_ff;

endmodule

// File: hw/rtl/accelerated_step_adjuster_top.sv
// top level of the accelerated step adjuster: control fsm plus datapath
// depends on asa_pkg, asa_req_if, asa_rsp_if, asa_ctrl and asa_dpath
//
// Keeps a signed 18-bit offset that step-up and step-down words move by a step
// size adapting to press rate; tick words advance a saturating elapsed counter,
// and each press restarts it. On a press: idle beyond idle_ticks restores the base
// step, slower than slow_ticks divides the step by ten (when above 5x base), and
// faster than fast_ticks multiplies it by ten (when below 500x base, capped at
// 1000000) if the offset rounded to the step is also a multiple of ten steps.
// Zero and cancel words set the offset to zero or to offset minus altitude, with
// saturation. Every word gives one response word. A step word occupies the block
// for the accepting cycle, which loads the divider, then 21 iterations of the
// restoring divider that decide the rounding test, then a commit that writes the
// response register; the next word can be taken once the commit is done. Tick,
// zero, cancel and unused codes spend a single divider iteration instead. The
// commit waits while the previous response is still unaccepted. The response
// sits in an output register, so the next request word is taken while a
// response still waits.
// The user must write registers through csr_we/csr_index/csr_wdata only while
// the block is idle; the block itself does not enforce this. A new base step is
// restored at the next idle press and sets the 5x/500x bounds at every later press.
module accelerated_step_adjuster_top import asa_pkg::*; #(
   parameter int ELAPSED_WIDTH = ELAPSED_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   asa_req_if.sink               req_chan,
   asa_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   asa_cmd_type    cmd;
   asa_status_type status;

   // sequencing: load, divider iterations, commit into the output register
   asa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .status    (status),
      .cmd       (cmd)
   );

   // state, registers, rounding divider and response payload
   asa_dpath #(
      .ELAPSED_WIDTH (ELAPSED_WIDTH)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_type     (req_chan.req_type),
      .req_altitude (req_chan.altitude),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .offset_out   (rsp_chan.offset_out),
      .changed      (rsp_chan.changed),
      .step_out     (rsp_chan.step_out)
   );

   // a shown step is never zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.step_out != '0))
      else $error("response step is zero");

   // one word at a time: an accepted word blocks the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request taken while busy");

   // a response rises only out of a busy state, such as the commit state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(!req_chan.ready))
      else $error("response raised outside commit");

endmodule
